// File: design/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

    localparam int PAT_BYTES       = 16;
    localparam int WIN_CAP         = PAT_BYTES - 1;
    localparam int LEN_W           = 5;
    localparam int OUT_COUNT_W     = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 5;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2
    } t_reg_idx;

    // Pattern laid out against the window: win_exp[k] is the byte expected k+1
    // places before the current one, win_use[k] says whether that place counts.
    typedef struct packed {
        logic [LEN_W-1:0]              len;
        logic [7:0]                    last_exp;
        logic [WIN_CAP-1:0][7:0]       win_exp;
        logic [WIN_CAP-1:0]            win_use;
    } t_match_cfg;

endpackage

// File: design/npc_if.sv
`timescale 1ns / 1ps

interface npc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface npc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               match_found;
    logic [npc_pkg::OUT_COUNT_W-1:0]    occurrence_count;
    logic                               stream_done;

    modport source (output valid, output match_found, output occurrence_count,
                    output stream_done, input ready);
    modport sink   (input valid, input match_found, input occurrence_count,
                    input stream_done, output ready);
endinterface

// File: design/nonoverlap_pattern_counter_unit.sv
`timescale 1ns / 1ps
// A request accepted into the input register moves on to the result register when that is free.
// Throughput: one byte per cycle while results are taken; the window compare and the count update sit
// between the input register and the result register, both advancing together.
// Reset (synchronous, active low): pattern 0, length 1, window, seen count,
// hold-off and running count cleared; both pipeline registers empty.
module nonoverlap_pattern_counter_unit #(
    parameter int MAX_PATTERN = npc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_WIDTH = npc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    npc_in_if.sink                          i_in,
    npc_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [npc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [npc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [npc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int OW = npc_pkg::OUT_COUNT_W;

    npc_pkg::t_match_cfg match_cfg;

    logic          r_s1_valid;
    logic [7:0]    r_s1_byte;
    logic          r_s1_last;
    logic          r_o_valid;
    logic          r_o_match;
    logic [OW-1:0] r_o_count;
    logic          r_o_done;

    logic          out_free;
    logic          adv;
    logic          hit;
    logic [OW-1:0] count;

    npc_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (match_cfg)
    );

    npc_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .i_cfg   (match_cfg),
        .o_hit   (hit),
        .o_count (count)
    );

    assign out_free   = !r_o_valid || o_out.ready;
    assign adv        = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    // Hold the result until taken; refill in the same cycle it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_match <= hit;
            r_o_count <= count;
            r_o_done  <= r_s1_last;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.match_found      = r_o_match;
    assign o_out.occurrence_count = r_o_count;
    assign o_out.stream_done      = r_o_done;

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last))
        else $error("input stage lost a request during a stall");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a staged request");

    a_done_count_zero_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_s1_last |=> (count == '0) || hit)
        else $error("count carried past the end of a stream");

endmodule

// File: design/npc_cfg.sv
`timescale 1ns / 1ps

module npc_cfg #(
    parameter int MAX_PATTERN = npc_pkg::MAX_PATTERN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [npc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [npc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [npc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output npc_pkg::t_match_cfg             o_cfg
);

    localparam int LW = npc_pkg::LEN_W;

    logic [63:0]   r_pat_low;
    logic [63:0]   r_pat_high;
    logic [LW-1:0] r_pat_len;
    npc_pkg::t_match_cfg r_cfg;
    npc_pkg::t_match_cfg n_cfg;

    npc_pkg::t_reg_idx reg_idx;
    logic              wr_en;
    logic [npc_pkg::PAT_BYTES-1:0][7:0] pat;
    logic [LW-1:0]     len_eff;
    logic [LW-1:0]     pos;

    assign reg_idx = npc_pkg::t_reg_idx'(paddr[4:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LW'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                npc_pkg::REG_PAT_LOW:  r_pat_low  <= pwdata;
                npc_pkg::REG_PAT_HIGH: r_pat_high <= pwdata;
                npc_pkg::REG_PAT_LEN:  r_pat_len  <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            npc_pkg::REG_PAT_LOW:  prdata = r_pat_low;
            npc_pkg::REG_PAT_HIGH: prdata = r_pat_high;
            npc_pkg::REG_PAT_LEN:  prdata = {{(npc_pkg::CFG_DATA_W-LW){1'b0}}, r_pat_len};
            default:               prdata = '0;
        endcase
    end

    // Clamp length, then align the pattern against the byte window.
    always_comb begin
        pat = {r_pat_high, r_pat_low};
        if (r_pat_len == '0) begin
            len_eff = LW'(1);
        end else if (r_pat_len > LW'(MAX_PATTERN)) begin
            len_eff = LW'(MAX_PATTERN);
        end else begin
            len_eff = r_pat_len;
        end
        n_cfg.len      = len_eff;
        pos            = len_eff - LW'(1);
        n_cfg.last_exp = pat[pos[3:0]];
        for (int k = 0; k < npc_pkg::WIN_CAP; k++) begin
            pos              = len_eff - LW'(2) - LW'(k);
            n_cfg.win_use[k] = (LW'(k + 1) < len_eff);
            n_cfg.win_exp[k] = pat[pos[3:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{len: LW'(1), last_exp: 8'd0, win_exp: '0, win_use: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/npc_match.sv
`timescale 1ns / 1ps

module npc_match #(
    parameter int MAX_PATTERN = npc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_WIDTH = npc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic [7:0]                          i_byte,
    input  logic                                i_last,
    input  npc_pkg::t_match_cfg                 i_cfg,
    output logic                                o_hit,
    output logic [npc_pkg::OUT_COUNT_W-1:0]     o_count
);

    localparam int WD     = MAX_PATTERN - 1;
    localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
    localparam int HOLD_W = $clog2(MAX_PATTERN);
    localparam int LW     = npc_pkg::LEN_W;
    localparam int OW     = npc_pkg::OUT_COUNT_W;
    localparam int EXT_W  = (COUNT_WIDTH > OW) ? COUNT_WIDTH : OW;

    logic [7:0]             r_win [0:WD-1];
    logic [SEEN_W-1:0]      r_seen;
    logic [HOLD_W-1:0]      r_holdoff;
    logic [COUNT_WIDTH-1:0] r_count;

    logic [HOLD_W-1:0]      n_holdoff;
    logic [SEEN_W-1:0]      n_seen;
    logic [COUNT_WIDTH-1:0] n_count;

    logic             win_ok;
    logic [LW:0]      seen_p1;
    logic             seen_ok;
    logic             hit;
    logic [EXT_W-1:0] cnt_ext;

    always_comb begin
        win_ok = 1'b1;
        for (int k = 0; k < WD; k++) begin
            if (i_cfg.win_use[k] && (r_win[k] != i_cfg.win_exp[k])) begin
                win_ok = 1'b0;
            end
        end
        seen_p1 = (LW + 1)'(r_seen) + (LW + 1)'(1);
        seen_ok = seen_p1 >= {1'b0, i_cfg.len};
        hit     = (r_holdoff == '0) && seen_ok && (i_byte == i_cfg.last_exp) && win_ok;

        if (hit && (r_count != '1)) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end else begin
            n_count = r_count;
        end

        // Block any match that overlaps the one just counted.
        if (hit) begin
            n_holdoff = HOLD_W'(i_cfg.len - LW'(1));
        end else if (r_holdoff != '0) begin
            n_holdoff = r_holdoff - HOLD_W'(1);
        end else begin
            n_holdoff = r_holdoff;
        end

        if (r_seen < SEEN_W'(MAX_PATTERN)) begin
            n_seen = r_seen + SEEN_W'(1);
        end else begin
            n_seen = r_seen;
        end

        cnt_ext = EXT_W'(n_count);
    end

    assign o_hit   = hit;
    assign o_count = (|(cnt_ext >> OW)) ? {OW{1'b1}} : cnt_ext[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WD; k++) begin
                r_win[k] <= 8'd0;
            end
            r_seen    <= '0;
            r_holdoff <= '0;
            r_count   <= '0;
        end else if (i_adv) begin
            if (i_last) begin
                for (int k = 0; k < WD; k++) begin
                    r_win[k] <= 8'd0;
                end
                r_seen    <= '0;
                r_holdoff <= '0;
                r_count   <= '0;
            end else begin
                r_win[0] <= i_byte;
                for (int k = 1; k < WD; k++) begin
                    r_win[k] <= r_win[k-1];
                end
                r_seen    <= n_seen;
                r_holdoff <= n_holdoff;
                r_count   <= n_count;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_last |=> (r_count == '0) && (r_seen == '0) && (r_holdoff == '0))
        else $error("stream state not cleared after last byte");

    a_no_hit_in_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_holdoff != '0) |-> !hit)
        else $error("match reported inside hold-off");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_adv) && !$past(i_last) |-> r_count >= $past(r_count))
        else $error("running count went backwards within a stream");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 80;
    localparam int REG_SPARE   = 3;   // no register lives here
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic                            match;
        logic [npc_pkg::OUT_COUNT_W-1:0] count;
        logic                            done;
    } t_count_result;

    logic i_clk;
    logic i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [npc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [npc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [npc_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    npc_in_if  in_if ();
    npc_out_if out_if ();

    nonoverlap_pattern_counter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the configuration and stream state.
    logic [63:0]                     pat_lo;
    logic [63:0]                     pat_hi;
    logic [npc_pkg::LEN_W-1:0]       pat_len;
    logic [7:0]                      window [npc_pkg::WIN_CAP];
    int                              seen_bytes;
    int                              hold_left;
    logic [npc_pkg::OUT_COUNT_W-1:0] run_count;

    t_count_result pending_counts[$];
    t_count_result want;
    int  error_count;
    bit  send_quiet;
    bit  recv_quiet;
    bit  hold_req;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, exp_val);
    endtask

    function automatic logic [7:0] pat_at(input int k);
        if (k < 8)
            return pat_lo[8*k +: 8];
        return pat_hi[8*(k-8) +: 8];
    endfunction

    function automatic int eff_len(input logic [npc_pkg::LEN_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > npc_pkg::PAT_BYTES)
            return npc_pkg::PAT_BYTES;
        return int'(raw);
    endfunction

    function automatic void clear_stream();
        for (int k = 0; k < npc_pkg::WIN_CAP; k++)
            window[k] = 8'h00;
        seen_bytes = 0;
        hold_left  = 0;
        run_count  = '0;
    endfunction

    // Advance the shadow by one byte and queue the count it should produce.
    function automatic void predict_count(input logic [7:0] b, input logic last);
        int            len;
        bit            hit;
        t_count_result r;
        len = eff_len(pat_len);
        hit = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
        end else if (seen_bytes + 1 >= len && b == pat_at(len - 1)) begin
            hit = 1'b1;
            for (int k = 0; k + 1 < len; k++)
                if (window[k] != pat_at(len - 2 - k))
                    hit = 1'b0;
        end
        if (hit) begin
            if (run_count != '1)
                run_count++;
            hold_left = len - 1;
        end
        for (int k = npc_pkg::WIN_CAP - 1; k > 0; k--)
            window[k] = window[k-1];
        window[0] = b;
        if (seen_bytes < npc_pkg::PAT_BYTES)
            seen_bytes++;
        r.match = hit;
        r.count = run_count;
        r.done  = last;
        pending_counts.push_back(r);
        if (last)
            clear_stream();
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic write_reg(input int idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= npc_pkg::CFG_ADDR_W'(idx * 8);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            npc_pkg::REG_PAT_LOW:  pat_lo = val;
            npc_pkg::REG_PAT_HIGH: pat_hi = val;
            npc_pkg::REG_PAT_LEN:  pat_len = val[npc_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!send_quiet && $urandom_range(99) < 20) begin
            gap = $urandom_range(1, 4);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_count(b, last);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_pattern(input logic [127:0] bits,
                                input logic [npc_pkg::LEN_W-1:0] len);
        write_reg(npc_pkg::REG_PAT_LOW, bits[63:0]);
        write_reg(npc_pkg::REG_PAT_HIGH, bits[127:64]);
        // Upper bits of the length word must be dropped by the block.
        write_reg(npc_pkg::REG_PAT_LEN, {32'($urandom), 27'($urandom), len});
    endtask

    task automatic run_phase(input logic [npc_pkg::LEN_W-1:0] len_reg, input int n_items);
        logic [7:0]   pat [npc_pkg::PAT_BYTES];
        logic [127:0] pat_bits;
        logic [7:0]   b;
        bit           narrow;
        int           eff;
        int           sent;
        int           bad;
        narrow = $urandom_range(1);
        for (int k = 0; k < npc_pkg::PAT_BYTES; k++) begin
            pat[k] = narrow ? 8'(8'h61 + $urandom_range(1)) : 8'($urandom);
            pat_bits[8*k +: 8] = pat[k];
        end
        drain_results();
        load_pattern(pat_bits, len_reg);
        eff  = eff_len(len_reg);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 45) begin
                // Plant a copy of the pattern, now and then with one byte spoiled.
                bad = ($urandom_range(3) == 0) ? int'($urandom_range(eff - 1)) : -1;
                for (int k = 0; k < eff; k++) begin
                    b = (k == bad) ? 8'($urandom) : pat[k];
                    send_byte(b, $urandom_range(49) == 0);
                    sent++;
                end
            end else begin
                b = $urandom_range(1) ? pat[$urandom_range(eff - 1)] : 8'($urandom);
                send_byte(b, $urandom_range(49) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_full_pattern();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        drain_results();
        load_pattern(bits, 5'd16);
        for (int k = 0; k < npc_pkg::PAT_BYTES; k++)
            send_byte(bits[8*k +: 8], k == npc_pkg::PAT_BYTES - 1);
    endtask

    task automatic test_overlap_holdoff();
        drain_results();
        load_pattern(128'h6161, 5'd2);
        write_reg(REG_SPARE, '1);
        // Third byte is held off; the fourth follows a stream end, too short to hit.
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'h61, 1'b0);
    endtask

    task automatic test_backpressure();
        drain_results();
        load_pattern(128'h616261, 5'd3);
        send_quiet = 1'b1;
        hold_req   = 1'b1;
        for (int k = 0; k < 60; k++)
            send_byte(8'(8'h61 + $urandom_range(1)), 1'b0);
        send_quiet = 1'b0;
    endtask

    task automatic test_full_rate();
        send_quiet = 1'b1;
        recv_quiet = 1'b1;
        run_phase(5'($urandom_range(1, npc_pkg::PAT_BYTES)), 150);
        drain_results();
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
    endtask

    task automatic test_random_streams();
        logic [npc_pkg::LEN_W-1:0] len_sel;
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       len_sel = 5'd0;
                1:       len_sel = 5'd31;
                2:       len_sel = 5'd17;
                3:       len_sel = 5'd16;
                4:       len_sel = 5'd1;
                default: len_sel = 5'($urandom_range(1, npc_pkg::PAT_BYTES));
            endcase
            // Streams are left open across phases, so config also lands mid-stream.
            run_phase(len_sel, 100);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_counts.size() == 0) begin
                report_mismatch("result with no request", 32'd0, 32'd0);
            end else begin
                want = pending_counts.pop_front();
                if (out_if.match_found !== want.match)
                    report_mismatch("match_found", 32'(out_if.match_found), 32'(want.match));
                if (out_if.occurrence_count !== want.count)
                    report_mismatch("occurrence_count", out_if.occurrence_count, want.count);
                if (out_if.stream_done !== want.done)
                    report_mismatch("stream_done", 32'(out_if.stream_done), 32'(want.done));
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                out_if.ready <= recv_quiet || ($urandom_range(99) >= 33);
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        error_count     = 0;
        send_quiet      = 1'b0;
        recv_quiet      = 1'b0;
        hold_req        = 1'b0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pat_lo          = '0;
        pat_hi          = '0;
        pat_len         = 5'd1;
        clear_stream();
        i_rst_n         = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_defaults();
        test_full_pattern();
        test_overlap_holdoff();
        test_backpressure();
        test_full_rate();
        test_random_streams();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
